/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
// Include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain implication property, checked outside reset.
`define SNE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Property checked at every edge, reset included.
`define SNE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/sne_pkg.sv */
// Shared types, widths and the divisor table for the spheremap encoder.
// No dependencies.
package sne_pkg;

    localparam int CompW  = 8;
    localparam int QuotW  = 15;          // quotient < 2^15 for byte inputs
    localparam int RemW   = 41;          // holds v<<32 and divisor<<14
    localparam int DivW   = 26;          // 255*f, f <= 2^18
    localparam int FracW  = 16;

    typedef logic [DivW-1:0] div_tab_t [256];

    // One word travelling along the divider chain
    typedef struct packed {
        logic [RemW-1:0]  rem_x;
        logic [RemW-1:0]  rem_y;
        logic [DivW-1:0]  dvs;
        logic [QuotW-1:0] q_x;
        logic [QuotW-1:0] q_y;
        logic             last;
    } cell_word_t;

    // Exact integer square root, used at elaboration only
    function automatic logic [63:0] isqrt64(input logic [63:0] a_in);
        logic [63:0] a;
        logic [63:0] res;
        logic [63:0] bitv;
        a    = a_in;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (a >= res + bitv) begin
                a   = a - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 255 * floor(sqrt(8*(z+1)) * 2^16) for every blue byte
    function automatic div_tab_t build_div_tab();
        div_tab_t    tab;
        logic [63:0] arg;
        logic [63:0] f;
        logic [63:0] d;
        for (int b = 0; b < 256; b++) begin
            arg    = ((64'(8 * (b + 255))) << 32) / 64'd255;
            f      = isqrt64(arg);
            d      = f * 64'd255;
            tab[b] = d[DivW-1:0];
        end
        return tab;
    endfunction

    localparam div_tab_t DivTab = build_div_tab();

endpackage

/* rtl/sne_div_cell.sv */
// One restoring-division cell: settles one quotient bit for x and y.
// Depends on sne_pkg.
module sne_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_vld,
    output logic               in_rdy,
    input  sne_pkg::cell_word_t in_word,
    output logic               out_vld,
    input  logic               out_rdy,
    output sne_pkg::cell_word_t out_word
);

    logic                vld_reg, vld_next;
    sne_pkg::cell_word_t word_reg, word_next;
    logic [sne_pkg::RemW-1:0] dsh;

    assign in_rdy = !vld_reg || out_rdy;
    assign dsh    = sne_pkg::RemW'(in_word.dvs) << SHIFT;

    // trial subtract on both components
    always_comb begin
        word_next = in_word;
        if (in_word.rem_x >= dsh) begin
            word_next.rem_x    = in_word.rem_x - dsh;
            word_next.q_x[SHIFT] = 1'b1;
        end
        if (in_word.rem_y >= dsh) begin
            word_next.rem_y    = in_word.rem_y - dsh;
            word_next.q_y[SHIFT] = 1'b1;
        end
        vld_next = in_rdy ? in_vld : vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_rdy && in_vld) begin
            word_reg <= word_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_word = word_reg;

endmodule

/* rtl/spheremap_normal_encode.sv */
// Top level of the spheremap normal encoder: table front, divider cell chain, output stage.
// Depends on sne_pkg, sne_div_cell and assert_macros.svh.
//
//  channel  | handshake          | word
//  ---------+--------------------+-------------------------------------
//  input    | s_valid / s_ready  | s_red, s_green, s_blue, s_last_in
//  result   | m_valid / m_ready  | m_enc_x, m_enc_y, m_last_out
//
// One word per cycle while m_ready holds; the stages are the divisor lookup, 15 divider
// cells (one quotient bit each), and the clamp/scale output register.
// Every stage holds a valid bit and takes a new word when empty or when
// its successor takes its word, so bubbles close up under a stall.
// aresetn is synchronous and clears all valid bits.
`include "assert_macros.svh"
module spheremap_normal_encode (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_red,
    input  logic [7:0] s_green,
    input  logic [7:0] s_blue,
    input  logic       s_last_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_enc_x,
    output logic [7:0] m_enc_y,
    output logic       m_last_out
);

    localparam int NCell = sne_pkg::QuotW;

    logic                vld [NCell+1];
    logic                rdy [NCell+1];
    sne_pkg::cell_word_t word [NCell+1];

    // front stage: divisor lookup and dividend setup
    logic                front_vld_reg;
    sne_pkg::cell_word_t front_word_reg, front_word_next;

    assign s_ready = !front_vld_reg || rdy[0];

    always_comb begin
        front_word_next.rem_x = {1'b0, s_red, 32'b0};
        front_word_next.rem_y = {1'b0, s_green, 32'b0};
        front_word_next.dvs   = sne_pkg::DivTab[s_blue];
        front_word_next.q_x   = '0;
        front_word_next.q_y   = '0;
        front_word_next.last  = s_last_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_vld_reg <= 1'b0;
        end else if (s_ready) begin
            front_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            front_word_reg <= front_word_next;
        end
    end

    assign vld[0]  = front_vld_reg;
    assign word[0] = front_word_reg;

    // divider chain, most significant quotient bit first
    for (genvar i = 0; i < NCell; i++) begin : g_cell
        sne_div_cell #(
            .SHIFT(NCell - 1 - i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .in_vld  (vld[i]),
            .in_rdy  (rdy[i]),
            .in_word (word[i]),
            .out_vld (vld[i+1]),
            .out_rdy (rdy[i+1]),
            .out_word(word[i+1])
        );
    end

    // output stage: add one half, clamp, scale by 255
    logic                      out_vld_reg;
    logic [7:0]                enc_x_reg, enc_y_reg, enc_x_next, enc_y_next;
    logic                      last_reg;
    logic [sne_pkg::FracW:0]   sum_x, sum_y, clp_x, clp_y;
    logic [sne_pkg::FracW+8:0] prod_x, prod_y;

    assign rdy[NCell] = !out_vld_reg || m_ready;

    always_comb begin
        sum_x  = (sne_pkg::FracW+1)'(word[NCell].q_x) + 17'h08000;
        sum_y  = (sne_pkg::FracW+1)'(word[NCell].q_y) + 17'h08000;
        clp_x  = (sum_x > 17'h10000) ? 17'h10000 : sum_x;
        clp_y  = (sum_y > 17'h10000) ? 17'h10000 : sum_y;
        prod_x = (sne_pkg::FracW+9)'(clp_x) * 25'd255;
        prod_y = (sne_pkg::FracW+9)'(clp_y) * 25'd255;
        enc_x_next = prod_x[sne_pkg::FracW+7:sne_pkg::FracW];
        enc_y_next = prod_y[sne_pkg::FracW+7:sne_pkg::FracW];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (rdy[NCell]) begin
            out_vld_reg <= vld[NCell];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[NCell] && vld[NCell]) begin
            enc_x_reg <= enc_x_next;
            enc_y_reg <= enc_y_next;
            last_reg  <= word[NCell].last;
        end
    end

    assign m_valid    = out_vld_reg;
    assign m_enc_x    = enc_x_reg;
    assign m_enc_y    = enc_y_reg;
    assign m_last_out = last_reg;

    // x and y offsets are non-negative, so bytes never drop below 127
    `SNE_ASSERT(a_enc_x_floor, aclk, aresetn, m_valid |-> m_enc_x >= 8'd127, "enc_x below half")
    `SNE_ASSERT(a_enc_y_floor, aclk, aresetn, m_valid |-> m_enc_y >= 8'd127, "enc_y below half")
    // an accepted input word lands in the front stage
    `SNE_ASSERT(a_front_load, aclk, aresetn, (s_valid && s_ready) |=> front_vld_reg, "front lost word")
    // the last cell leaves a remainder below the divisor
    `SNE_ASSERT(a_rem_done, aclk, aresetn, vld[NCell] |-> (word[NCell].rem_x < 41'(word[NCell].dvs)), "x remainder not reduced")

endmodule
